[hw/rtl/softmax_with_temperature_defines.svh]
// ----------------------------------------------------------------------------
// Softmax with temperature: assertion macros
// Shared property shorthands for the checker of the softmax block.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_WITH_TEMPERATURE_DEFINES_SVH
`define SOFTMAX_WITH_TEMPERATURE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/smt_pkg.sv]
// ----------------------------------------------------------------------------
// Softmax with temperature: package
// Field widths, fixed-point constants and the elaboration-time builder of
// the 2^-f lookup table.
// ----------------------------------------------------------------------------
package smt_pkg;

	localparam int LOGIT_W = 16;
	localparam int INV_W = 16;
	localparam int PROB_W = 16;
	localparam int CLS_W = 4;
	localparam int EXP_W = 16;
	localparam int SHIFT_W = 4;
	localparam int FRAC_BITS = 20;
	localparam int DIVIDEND_W = EXP_W + PROB_W - 1;

	localparam int SMT_MAX_CLASSES = 16;
	localparam int SMT_EXP_TABLE_DEPTH = 64;

	localparam logic [INV_W-1:0] INV_T_RESET = 16'd4096;
	localparam logic [15:0] LOG2E_Q15 = 16'd47274;
	localparam logic [PROB_W-1:0] PROB_SCALE = 16'hFFFF;
	localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 16'sh8000;

	// D-fold truncating product of a Q0.32 value, result in Q32.
	function automatic logic [63:0] smt_pow_q32(input logic [63:0] v, input int count);
		logic [127:0] acc;
		acc = 128'h1_0000_0000;
		for (int i = 0; i < count; i++) begin
			acc = (acc * {64'd0, v}) >> 32;
		end
		return acc[63:0];
	endfunction

	// Smallest Q0.32 ratio whose depth-fold product reaches one half.
	function automatic logic [63:0] smt_exp_root(input int depth);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'h8000_0000;
		hi = 64'hFFFF_FFFF;
		for (int s = 0; s < 40; s++) begin
			if (hi - lo > 64'd1) begin
				mid = lo + ((hi - lo) >> 1);
				if (smt_pow_q32(mid, depth) >= 64'h8000_0000)
					hi = mid;
				else
					lo = mid;
			end
		end
		return hi;
	endfunction

	// Entry k of the table: the k-th power of the root, rounded to Q1.15.
	function automatic logic [15:0] smt_exp_entry(input int k, input logic [63:0] root);
		logic [127:0] p;
		logic [127:0] r;
		p = 128'h1_0000_0000;
		for (int i = 0; i < k; i++) begin
			p = (p * {64'd0, root}) >> 32;
		end
		r = (p + 128'h1_0000) >> 17;
		return r[15:0];
	endfunction

endpackage

[hw/rtl/smt_exp_rom.sv]
// ----------------------------------------------------------------------------
// Softmax with temperature: exponential lookup
// Constant 2^-f table in Q1.15 followed by the integer-part right shift.
// ----------------------------------------------------------------------------
module smt_exp_rom
	import smt_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = SMT_EXP_TABLE_DEPTH,
	localparam int TAB_IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input  logic [TAB_IDX_W-1:0] tab_idx,
	input  logic [SHIFT_W-1:0]   shift,
	input  logic                 underflow,
	output logic [EXP_W-1:0]     exp_val
);

	localparam logic [63:0] ROOT = smt_exp_root(EXP_TABLE_DEPTH);

	logic [EXP_W-1:0] tab [EXP_TABLE_DEPTH];

	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
		localparam logic [EXP_W-1:0] ENTRY = smt_exp_entry(k, ROOT);
		assign tab[k] = ENTRY;
	end

	// A shift of sixteen or more leaves nothing of a Q1.15 value.
	assign exp_val = underflow ? '0 : (tab[tab_idx] >> shift);

endmodule

[hw/rtl/smt_divider.sv]
// ----------------------------------------------------------------------------
// Softmax with temperature: divider
// Restoring divider, one quotient bit per cycle, for scaled exponential
// over the row sum.
// ----------------------------------------------------------------------------
module smt_divider
	import smt_pkg::*;
#(
	parameter int SUM_W = EXP_W + $clog2(SMT_MAX_CLASSES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [SUM_W-1:0]      divisor,
	output logic                  done,
	output logic [PROB_W-1:0]     quotient
);

	localparam int STEP_W = $clog2(PROB_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [SUM_W-1:0]  rem_q;
	logic [PROB_W-1:0] low_q;
	logic [PROB_W-1:0] quo_q;
	logic [SUM_W-1:0]  div_q;

	logic [SUM_W:0] trial;
	logic [SUM_W:0] diff;
	logic           fits;

	// The dividend never exceeds divisor * 2^16, so the high part starts
	// below the divisor and each partial remainder stays below it.
	assign trial = {rem_q, low_q[PROB_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(PROB_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(dividend[DIVIDEND_W-1:PROB_W]);
			low_q <= dividend[PROB_W-1:0];
			quo_q <= '0;
			div_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			low_q <= {low_q[PROB_W-2:0], 1'b0};
			quo_q <= {quo_q[PROB_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = (div_q == '0) ? '0 : quo_q;

endmodule

[hw/rtl/softmax_with_temperature.sv]
// ----------------------------------------------------------------------------
// Softmax with temperature: top level
//
//   channel  direction  handshake              payload
//   config   in         cfg_we                 cfg_wdata (inverse temperature)
//   input    in         in_valid / in_stall    logit, row_end
//   output   out        out_valid / out_stall  probability, class_index,
//                                              row_last, overflowed
//
// Loading accepts one logit per cycle. After the row end, an exponential
// pass and then a division pass run over the elements, the division pass
// waiting while the output is stalled; they use one shared 32x16 multiplier
// and a 16-step restoring divider. in_stall stays high from the row end
// until the last result of the row is transferred. Reset clears the row
// state and sets the inverse temperature to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module softmax_with_temperature
	import smt_pkg::*;
#(
	parameter int MAX_CLASSES = SMT_MAX_CLASSES,
	parameter int EXP_TABLE_DEPTH = SMT_EXP_TABLE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [INV_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [LOGIT_W-1:0] logit,
	input  logic                      row_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PROB_W-1:0]         probability,
	output logic [CLS_W-1:0]          class_index,
	output logic                      row_last,
	output logic                      overflowed
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int SUM_W = EXP_W + $clog2(MAX_CLASSES);
	localparam int TAB_IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int SCALE_W = FRAC_BITS + TAB_IDX_W;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int U_W = PROD_W - 15;

	typedef enum logic [3:0] {
		S_LOAD,
		S_X_RD,
		S_X_MUL1,
		S_X_MUL2,
		S_X_IDX,
		S_X_LUT,
		S_D_RD,
		S_D_MUL,
		S_D_START,
		S_D_WAIT,
		S_OUT
	} state_t;

	state_t                    state_q;
	logic [INV_W-1:0]          inv_q;
	logic signed [LOGIT_W-1:0] max_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;
	logic [IDX_W-1:0]          i_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      zero_q;
	logic [SHIFT_W-1:0]        shift_q;
	logic [TAB_IDX_W-1:0]      tidx_q;
	logic                      out_valid_q;
	logic [PROB_W-1:0]         prob_q;
	logic [CLS_W-1:0]          cls_q;
	logic                      last_q;
	logic                      ovf_out_q;
	logic [PROD_W-1:0]         prod_q;
	logic [LOGIT_W-1:0]        rd_q;

	logic [LOGIT_W-1:0] elem_mem [MAX_CLASSES];

	logic                 full;
	logic                 i_last;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [LOGIT_W-1:0]   mem_wdata;
	logic [LOGIT_W-1:0]   diff;
	logic                 mul_en;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [U_W-1:0]       u;
	logic [SCALE_W-1:0]   scaled;
	logic [EXP_W-1:0]     exp_val;
	logic                 div_done;
	logic [PROB_W-1:0]    quotient;

	assign full   = cnt_q == CNT_W'(MAX_CLASSES);
	assign i_last = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;

	// The maximum covers every stored logit, so the difference is an exact
	// unsigned Q8.8 value.
	assign diff = max_q - rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inv_q <= INV_T_RESET;
		else if (cfg_we)
			inv_q <= cfg_wdata;
	end

	// One store: logits while loading, overwritten in place by exponentials.
	assign mem_we    = (state_q == S_LOAD && in_valid && !full) || state_q == S_X_LUT;
	assign mem_waddr = (state_q == S_LOAD) ? cnt_q[IDX_W-1:0] : i_q;
	assign mem_wdata = (state_q == S_LOAD) ? logit : exp_val;

	always_ff @(posedge clk) begin
		if (mem_we)
			elem_mem[mem_waddr] <= mem_wdata;
		rd_q <= elem_mem[i_q];
	end

	always_comb begin
		mul_en = 1'b1;
		case (state_q)
			S_X_MUL1: begin
				mul_a = MUL_A_W'(diff);
				mul_b = inv_q;
			end
			S_X_MUL2: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = LOG2E_Q15;
			end
			S_D_MUL: begin
				mul_a = MUL_A_W'(rd_q);
				mul_b = PROB_SCALE;
			end
			default: begin
				mul_en = 1'b0;
				mul_a  = '0;
				mul_b  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Base-2 exponent with 20 fraction bits; the fraction picks the entry.
	assign u      = prod_q[PROD_W-1:15];
	assign scaled = SCALE_W'(u[FRAC_BITS-1:0]) * SCALE_W'(EXP_TABLE_DEPTH);

	smt_exp_rom #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_exp_rom (
		.tab_idx  (tidx_q),
		.shift    (shift_q),
		.underflow(zero_q),
		.exp_val  (exp_val)
	);

	smt_divider #(
		.SUM_W(SUM_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_D_START),
		.dividend(prod_q[DIVIDEND_W-1:0]),
		.divisor (sum_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			max_q       <= LOGIT_MIN;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			sum_q       <= '0;
			zero_q      <= 1'b0;
			shift_q     <= '0;
			tidx_q      <= '0;
			out_valid_q <= 1'b0;
			prob_q      <= '0;
			cls_q       <= '0;
			last_q      <= 1'b0;
			ovf_out_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (logit > max_q)
								max_q <= logit;
						end else begin
							ovf_q <= 1'b1;
						end
						if (row_end) begin
							i_q     <= '0;
							sum_q   <= '0;
							state_q <= S_X_RD;
						end
					end
				end
				S_X_RD:   state_q <= S_X_MUL1;
				S_X_MUL1: state_q <= S_X_MUL2;
				S_X_MUL2: state_q <= S_X_IDX;
				S_X_IDX: begin
					zero_q  <= |u[U_W-1:FRAC_BITS+SHIFT_W];
					shift_q <= u[FRAC_BITS +: SHIFT_W];
					tidx_q  <= scaled[FRAC_BITS +: TAB_IDX_W];
					state_q <= S_X_LUT;
				end
				S_X_LUT: begin
					sum_q <= sum_q + SUM_W'(exp_val);
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_D_RD;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_X_RD;
					end
				end
				S_D_RD:    state_q <= S_D_MUL;
				S_D_MUL:   state_q <= S_D_START;
				S_D_START: state_q <= S_D_WAIT;
				S_D_WAIT: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						prob_q      <= quotient;
						cls_q       <= CLS_W'(i_q);
						last_q      <= i_last;
						ovf_out_q   <= ovf_q;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							max_q   <= LOGIT_MIN;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							sum_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= S_D_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_stall    = state_q != S_LOAD;
	assign out_valid   = out_valid_q;
	assign probability = prob_q;
	assign class_index = cls_q;
	assign row_last    = last_q;
	assign overflowed  = ovf_out_q;

endmodule

[hw/rtl/smt_checker.sv]
// ----------------------------------------------------------------------------
// Softmax with temperature: port checker
// Watches the top-level ports for ordering between loading and emitting.
// ----------------------------------------------------------------------------
`include "softmax_with_temperature_defines.svh"

module smt_checker
	import smt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              row_end,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PROB_W-1:0] probability,
	input logic [CLS_W-1:0]  class_index,
	input logic              row_last,
	input logic              overflowed
);

	// Results are only offered while the input side is held off.
	`SMT_ASSERT_SAME(a_out_while_stalled, clk, arst_n, out_valid, in_stall, "result offered while input open")

	// A transfer that ends a row starts the computation at once.
	`SMT_ASSERT_NEXT(a_row_end_stalls, clk, arst_n, in_valid && !in_stall && row_end, in_stall, "input not stalled after row end")

	// Once the last result of a row is transferred, loading resumes.
	`SMT_ASSERT_NEXT(a_last_reopens, clk, arst_n, out_valid && !out_stall && row_last, !in_stall && !out_valid, "input not reopened after last result")

	// A stalled result holds.
	`SMT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(probability) && $stable(class_index) && $stable(row_last) && $stable(overflowed), "stalled result changed")

endmodule

bind softmax_with_temperature smt_checker u_smt_checker (.*);
